>>> src/qask_pkg.sv
// Shared types, constants and the symbol decision function of the four-level demodulator.
package qask_pkg;

   localparam int SAMPLE_W = 32;
   localparam int AMP_W    = 31;
   localparam int RUN_W    = 16;
   localparam int INDEX_W  = 18;

   localparam logic [AMP_W-1:0] AMP_RESET = 31'h7F00_0000;
   localparam logic [RUN_W-1:0] RUN_MAX   = 16'hFFFF;

   typedef struct packed {
      logic [AMP_W-3:0] quarter;
      logic [AMP_W-2:0] half;
      logic [AMP_W-1:0] three_q;
   } qask_thresh_type;

   localparam qask_thresh_type THRESH_RESET = '{
      quarter: AMP_RESET[AMP_W-1:2],
      half:    AMP_RESET[AMP_W-1:1],
      three_q: 31'h5F40_0000
   };

   // One beat's instruction from the sync control to the slicer.
   typedef struct packed {
      logic             take;
      logic [RUN_W-1:0] baud_length;
   } qask_baud_cmd_type;

   localparam logic [1:0] SYM_LOW   = 2'd0;
   localparam logic [1:0] SYM_MID_L = 2'd1;
   localparam logic [1:0] SYM_MID_H = 2'd2;
   localparam logic [1:0] SYM_HIGH  = 2'd3;

   // Strict compare of a signed value against the three unsigned thresholds.
   // The half threshold is tested first: for tiny amplitudes 3*(amp/4) can sit below amp/2.
   function automatic logic [1:0] qask_decide(input logic [SAMPLE_W-1:0] v,
                                              input qask_thresh_type th);
      logic pos;
      logic [1:0] sym;
      pos = ~v[SAMPLE_W-1];
      if (pos && (v[AMP_W-1:0] > {1'b0, th.half})) begin
         sym = (v[AMP_W-1:0] > th.three_q) ? SYM_HIGH : SYM_MID_H;
      end else if (pos && (v[AMP_W-1:0] > {2'b00, th.quarter})) begin
         sym = SYM_MID_L;
      end else begin
         sym = SYM_LOW;
      end
      return sym;
   endfunction

endpackage

>>> src/qask_sync_ctrl.sv
// Sync acquisition: leading zero count, check samples, preamble skip.
module qask_sync_ctrl
   import qask_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [SAMPLE_W-1:0]     sample,
   output qask_baud_cmd_type       cmd
);

   localparam logic [2:0] PH_COUNT  = 3'd0;
   localparam logic [2:0] PH_CHECK  = 3'd1;
   localparam logic [2:0] PH_SKIP   = 3'd2;
   localparam logic [2:0] PH_BAUD   = 3'd3;
   localparam logic [2:0] PH_SILENT = 3'd4;

   logic [2:0]         phase_ff, phase_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [RUN_W-1:0]   zrun_ff, zrun_in;
   logic [RUN_W-1:0]   blen_ff, blen_in;
   logic               chk_ff, chk_in;

   logic               is_zero;
   logic [INDEX_W-1:0] two_z;
   logic [RUN_W-1:0]   blen_new;
   logic               take;

   assign is_zero  = (sample == '0);
   assign two_z    = {1'b0, zrun_ff, 1'b0};
   assign blen_new = (chk_ff && is_zero) ? zrun_ff : zrun_ff - 1'b1;

   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      zrun_in  = zrun_ff;
      blen_in  = blen_ff;
      chk_in   = chk_ff;
      take     = 1'b0;
      case (phase_ff)
         PH_COUNT: begin
            index_in = index_ff + 1'b1;
            if (is_zero) begin
               zrun_in = zrun_ff + 1'b1;
               if (zrun_ff == RUN_MAX - 1'b1) begin
                  phase_in = PH_CHECK;
               end
            end else if (zrun_ff < RUN_W'(2)) begin
               phase_in = PH_SILENT;
            end else begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            index_in = index_ff + 1'b1;
            if (index_ff == two_z - 1'b1) begin
               chk_in = ~is_zero;
            end else if (index_ff == two_z) begin
               blen_in = blen_new;
               if ({blen_new, 2'b00} == index_ff) begin
                  phase_in = PH_BAUD;
                  take     = 1'b1;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            index_in = index_ff + 1'b1;
            if (index_ff == {blen_ff, 2'b00}) begin
               phase_in = PH_BAUD;
               take     = 1'b1;
            end
         end
         PH_BAUD: begin
            take = 1'b1;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // first baud may start on the sample that fixes the baud length
   assign cmd.take        = take;
   assign cmd.baud_length = (phase_ff == PH_CHECK) ? blen_new : blen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         index_ff <= '0;
         zrun_ff  <= '0;
         blen_ff  <= '0;
         chk_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         zrun_ff  <= zrun_in;
         blen_ff  <= blen_in;
         chk_ff   <= chk_in;
      end
   end

endmodule

>>> src/qask_baud_slicer.sv
// Per-baud running maximum and four-level symbol decision.
module qask_baud_slicer
   import qask_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [SAMPLE_W-1:0] sample,
   input  qask_baud_cmd_type   cmd,
   input  qask_thresh_type     thresh,
   output logic                emit,
   output logic [1:0]          symbol
);

   logic [RUN_W-1:0]    pos_ff, pos_in;
   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic                use_new;
   logic                last;
   logic [RUN_W:0]      pos_next;

   assign use_new  = (pos_ff == '0) || ($signed(sample) > $signed(peak_ff));
   assign pos_next = {1'b0, pos_ff} + 1'b1;
   assign last     = pos_next >= {1'b0, cmd.baud_length};
   assign peak_in  = use_new ? sample : peak_ff;
   assign pos_in   = last ? '0 : pos_next[RUN_W-1:0];

   // decide on both candidates in parallel, then pick
   assign symbol = use_new ? qask_decide(sample, thresh) : qask_decide(peak_ff, thresh);
   assign emit   = cmd.take && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (advance && cmd.take) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && cmd.take) begin
         peak_ff <= peak_in;
      end
   end

endmodule

>>> src/qask_sync_demodulator.sv
// Top level of the four-level amplitude-shift-keying demodulator.
//
//   channel  | ports                        | beat
//   ---------+------------------------------+-------------------------------
//   req      | req_valid req_ready req_sample | one signed 32-bit sample
//   rsp      | rsp_valid rsp_ready rsp_symbol | one 2-bit symbol per baud
//   csr      | csr_valid csr_ready csr_data   | amplitude write (31 bits)
//
// One sample per cycle while rsp does not stall: input register, one pass of sync control and
// running-maximum/threshold logic, then the output register.
// On the last sample of a baud, the sample passes the input register, then its symbol the output register.
// The input register advances whenever the output register is empty or
// being taken, so a stalled rsp stalls req only once both stages are full.
// Synchronous reset restores amplitude thresholds and restarts sync search;
// csr_ready is always high and thresholds are precomputed at write time.
module qask_sync_demodulator
   import qask_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_symbol,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [AMP_W-1:0]    csr_data
);

   qask_thresh_type     thresh_ff, thresh_in;
   logic                s1_valid_ff, s1_valid_in;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_symbol_ff;

   logic                advance;
   qask_baud_cmd_type   cmd;
   logic                emit;
   logic [1:0]          symbol;

   // thresholds: amp/4, amp/2, 3*(amp/4)
   assign thresh_in.quarter = csr_data[AMP_W-1:2];
   assign thresh_in.half    = csr_data[AMP_W-1:1];
   assign thresh_in.three_q = {2'b00, csr_data[AMP_W-1:2]} + {1'b0, csr_data[AMP_W-1:2], 1'b0};

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_valid) begin
         thresh_ff <= thresh_in;
      end
   end

   // pipeline control
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = req_valid ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_sample_ff <= req_sample;
      end
      if (advance && emit) begin
         rsp_symbol_ff <= symbol;
      end
   end

   qask_sync_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (s1_sample_ff),
      .cmd     (cmd)
   );

   qask_baud_slicer u_slicer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (s1_sample_ff),
      .cmd     (cmd),
      .thresh  (thresh_ff),
      .emit    (emit),
      .symbol  (symbol)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("stage advanced into a stalled output register");

   a_full_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && s1_valid_ff) |-> advance)
      else $error("input register overwritten without advancing");

   a_emit_take: assert property (@(posedge clock) disable iff (reset)
      emit |-> cmd.take)
      else $error("symbol emitted outside a baud");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
